### design/pss_pkg.sv
// shared types, unit table and codes for the pinyin syllable segmenter
`default_nettype none

package pss_pkg;

  localparam int UNIT_COUNT = 57;
  localparam int WIN_DEPTH  = 4;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 3;
  localparam int LEN_W      = 3;
  localparam int CHAR_W     = 8;

  typedef enum logic [1:0] {
    K_ATOM  = 2'd0,
    K_MAJOR = 2'd1,
    K_MINOR = 2'd2,
    K_MAJIN = 2'd3
  } kind_t;

  // text is left aligned: first char in bits [31:24]
  typedef struct packed {
    logic [WIN_DEPTH*CHAR_W-1:0] text;
    logic [LEN_W-1:0]            len;
    kind_t                       kind;
  } unit_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_FLUSH,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic append;
    logic step;
    logic final_word;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             out_free;
  } status_t;

  localparam unit_t UNITS [UNIT_COUNT] = '{
    '{"iang", 3'd4, K_MINOR}, '{"iong", 3'd4, K_MINOR}, '{"uang", 3'd4, K_MINOR},
    '{{"ang", 8'h00}, 3'd3, K_MAJIN}, '{{"eng", 8'h00}, 3'd3, K_MAJIN},
    '{{"ian", 8'h00}, 3'd3, K_MINOR}, '{{"iao", 8'h00}, 3'd3, K_MINOR},
    '{{"ing", 8'h00}, 3'd3, K_MINOR}, '{{"ong", 8'h00}, 3'd3, K_MINOR},
    '{{"uai", 8'h00}, 3'd3, K_MINOR}, '{{"uan", 8'h00}, 3'd3, K_MINOR},
    '{{"ai", 16'h0}, 3'd2, K_MAJIN}, '{{"an", 16'h0}, 3'd2, K_MAJIN},
    '{{"ao", 16'h0}, 3'd2, K_MAJIN}, '{{"ch", 16'h0}, 3'd2, K_MAJOR},
    '{{"ei", 16'h0}, 3'd2, K_MAJIN}, '{{"en", 16'h0}, 3'd2, K_MAJIN},
    '{{"er", 16'h0}, 3'd2, K_ATOM},  '{{"ia", 16'h0}, 3'd2, K_MINOR},
    '{{"ie", 16'h0}, 3'd2, K_MINOR}, '{{"in", 16'h0}, 3'd2, K_MINOR},
    '{{"iu", 16'h0}, 3'd2, K_MINOR}, '{{"ou", 16'h0}, 3'd2, K_MAJIN},
    '{{"sh", 16'h0}, 3'd2, K_MAJOR}, '{{"ua", 16'h0}, 3'd2, K_MINOR},
    '{{"ue", 16'h0}, 3'd2, K_MINOR}, '{{"ui", 16'h0}, 3'd2, K_MINOR},
    '{{"un", 16'h0}, 3'd2, K_MINOR}, '{{"uo", 16'h0}, 3'd2, K_MINOR},
    '{{"ve", 16'h0}, 3'd2, K_MINOR}, '{{"zh", 16'h0}, 3'd2, K_MAJOR},
    '{{"a", 24'h0}, 3'd1, K_MAJIN}, '{{"b", 24'h0}, 3'd1, K_MAJOR},
    '{{"c", 24'h0}, 3'd1, K_MAJOR}, '{{"d", 24'h0}, 3'd1, K_MAJOR},
    '{{"e", 24'h0}, 3'd1, K_MAJIN}, '{{"f", 24'h0}, 3'd1, K_MAJOR},
    '{{"g", 24'h0}, 3'd1, K_MAJOR}, '{{"h", 24'h0}, 3'd1, K_MAJOR},
    '{{"i", 24'h0}, 3'd1, K_MINOR}, '{{"j", 24'h0}, 3'd1, K_MAJOR},
    '{{"k", 24'h0}, 3'd1, K_MAJOR}, '{{"l", 24'h0}, 3'd1, K_MAJOR},
    '{{"m", 24'h0}, 3'd1, K_MAJOR}, '{{"n", 24'h0}, 3'd1, K_MAJOR},
    '{{"o", 24'h0}, 3'd1, K_MAJIN}, '{{"p", 24'h0}, 3'd1, K_MAJOR},
    '{{"q", 24'h0}, 3'd1, K_MAJOR}, '{{"r", 24'h0}, 3'd1, K_MAJOR},
    '{{"s", 24'h0}, 3'd1, K_MAJOR}, '{{"t", 24'h0}, 3'd1, K_MAJOR},
    '{{"u", 24'h0}, 3'd1, K_MINOR}, '{{"v", 24'h0}, 3'd1, K_MINOR},
    '{{"w", 24'h0}, 3'd1, K_MAJOR}, '{{"x", 24'h0}, 3'd1, K_MAJOR},
    '{{"y", 24'h0}, 3'd1, K_MAJOR}, '{{"z", 24'h0}, 3'd1, K_MAJOR}
  };

endpackage

`default_nettype wire

### design/pss_ctrl.sv
// controller state machine for the pinyin syllable segmenter
`default_nettype none

module pss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_char_valid,
  input  wire logic            in_end,
  output logic                 in_ready,
  input  wire pss_pkg::status_t status,
  output pss_pkg::cmd_t        cmd
);
  import pss_pkg::*;

  state_t state, state_next;
  logic   end_seen, end_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      end_seen <= 1'b0;
    end else begin
      state    <= state_next;
      end_seen <= end_seen_next;
    end
  end

  always_comb begin
    state_next    = state;
    end_seen_next = end_seen;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.append    = in_char_valid;
          end_seen_next = in_end;
          if (in_char_valid && status.count == CNT_W'(WIN_DEPTH - 1)) begin
            state_next = S_MATCH;
          end else if (in_end) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_MATCH: begin
        if (status.out_free) begin
          cmd.step   = 1'b1;
          state_next = end_seen ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status.count == '0) begin
          state_next = S_FINAL;
        end else if (status.out_free) begin
          cmd.step = 1'b1;
        end
      end
      S_FINAL: begin
        if (status.out_free) begin
          cmd.final_word = 1'b1;
          end_seen_next  = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/pss_datapath.sv
// lookahead window, unit matcher, syllable builder and output register
`default_nettype none

module pss_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pss_pkg::cmd_t                     cmd,
  output pss_pkg::status_t                       status,
  input  wire logic [pss_pkg::CHAR_W-1:0]        char_code,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_syllable_valid,
  output logic [pss_pkg::IDX_W-1:0]              out_major,
  output logic                                   out_minor_valid,
  output logic [pss_pkg::IDX_W-1:0]              out_minor,
  output logic                                   out_last
);
  import pss_pkg::*;

  logic [CHAR_W-1:0] win [WIN_DEPTH];
  logic [CHAR_W-1:0] win_next [WIN_DEPTH];
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  pend_major;
  logic [IDX_W-1:0]  pend_minor;
  logic              pend_open;
  logic              pend_has_minor;
  logic              awaiting;

  logic [UNIT_COUNT-1:0] unit_hit;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  kind_t                 hit_kind;
  logic [LEN_W-1:0]      used;
  logic                  take_minor;
  logic                  open_new;
  logic                  emit;
  logic                  out_free;

  // per-unit prefix compare
  always_comb begin
    for (int u = 0; u < UNIT_COUNT; u++) begin
      unit_hit[u] = (UNITS[u].len <= count);
      for (int k = 0; k < WIN_DEPTH; k++) begin
        if (LEN_W'(k) < UNITS[u].len &&
            UNITS[u].text[(WIN_DEPTH-1-k)*CHAR_W +: CHAR_W] != win[k]) begin
          unit_hit[u] = 1'b0;
        end
      end
    end
  end

  // first hit wins: table is longest first
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int u = UNIT_COUNT - 1; u >= 0; u--) begin
      if (unit_hit[u]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(u);
      end
    end
  end

  assign hit_kind   = UNITS[hit_idx].kind;
  assign take_minor = hit && awaiting && hit_kind[1];
  assign open_new   = hit && !take_minor &&
                      (awaiting || hit_kind == K_ATOM || hit_kind[0]);
  assign emit       = open_new && pend_open;
  assign out_free   = !out_valid || out_ready;

  always_comb begin
    used = hit ? UNITS[hit_idx].len : LEN_W'(1);
    if (used > count) begin
      used = count;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_next[i] = win[i];
      for (int s = 1; s < WIN_DEPTH - i; s++) begin
        if (used == LEN_W'(s)) begin
          win_next[i] = win[i + s];
        end
      end
    end
  end

  assign status.count    = count;
  assign status.out_free = out_free;

  // window storage
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      win[count[1:0]] <= char_code;
    end else if (cmd.step) begin
      win <= win_next;
    end
  end

  // control state of the syllable builder
  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      pend_open      <= 1'b0;
      pend_has_minor <= 1'b0;
      awaiting       <= 1'b0;
    end else if (cmd.final_word) begin
      count          <= '0;
      pend_open      <= 1'b0;
      pend_has_minor <= 1'b0;
      awaiting       <= 1'b0;
    end else if (cmd.append) begin
      count <= count + CNT_W'(1);
    end else if (cmd.step) begin
      count <= count - used;
      if (take_minor) begin
        pend_has_minor <= 1'b1;
        awaiting       <= 1'b0;
      end else if (open_new) begin
        pend_open      <= 1'b1;
        pend_has_minor <= 1'b0;
        awaiting       <= (hit_kind == K_MAJOR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && take_minor) begin
      pend_minor <= hit_idx;
    end
    if (cmd.step && open_new) begin
      pend_major <= hit_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.step && emit) || cmd.final_word) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.step && emit) || cmd.final_word) begin
      out_syllable_valid <= pend_open;
      out_major          <= pend_open ? pend_major : '0;
      out_minor_valid    <= pend_open && pend_has_minor;
      out_minor          <= (pend_open && pend_has_minor) ? pend_minor : '0;
      out_last           <= cmd.final_word;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WIN_DEPTH))
    else $error("window count beyond depth");

  a_step_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> count != '0)
    else $error("match step on empty window");

  a_await_open: assert property (@(posedge clk) disable iff (rst)
    awaiting |-> pend_open && !pend_has_minor)
    else $error("awaiting final without bare open syllable");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.final_word |=> count == '0 && !pend_open && out_valid && out_last)
    else $error("end of text did not clear state");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.final_word) |-> out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

### design/pinyin_syllable_segmenter.sv
// top level of the pinyin syllable segmenter
//
//  channel | dir | tdata                          | tuser                     | tlast
//  s_*     | in  | [7:0] char_code                | [0] char_valid            | end_of_text
//  m_*     | out | [5:0] major_index, [11:6] minor_index, [15:12] zero
//          |     |                                | [0] syllable_valid, [1] minor_valid | last_result
//
// a character that leaves the window short of full is taken in idle; a character that
// fills the four-byte window is followed by a match state for the combinational table match
// at end of text the flush state steps through the remaining matches (at most three after
// that match), sees the window empty, and the final state then gives the last word
// a match or final word waits while the output register holds an untaken word
// synchronous reset clears the window count and the syllable state; no clearing pass
`default_nettype none

module pinyin_syllable_segmenter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic [0:0]  s_tuser,   // [0] char_valid
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [5:0] major_index, [11:6] minor_index
  output logic [1:0]       m_tuser,   // [0] syllable_valid, [1] minor_valid
  output logic             m_tlast
);
  import pss_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic             syl_valid;
  logic [IDX_W-1:0] major_index;
  logic             minor_valid;
  logic [IDX_W-1:0] minor_index;

  pss_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_char_valid (s_tuser[0]),
    .in_end        (s_tlast),
    .in_ready      (s_tready),
    .status        (status),
    .cmd           (cmd)
  );

  pss_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .char_code          (s_tdata),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_syllable_valid (syl_valid),
    .out_major          (major_index),
    .out_minor_valid    (minor_valid),
    .out_minor          (minor_index),
    .out_last           (m_tlast)
  );

  assign m_tdata = {4'h0, minor_index, major_index};
  assign m_tuser = {minor_valid, syl_valid};

endmodule

`default_nettype wire
